// ===== rtl/mmsm_pkg.sv =====
// Package: descriptor and entry word types, E820 class codes, type mapping.
`timescale 1ns / 1ps
package mmsm_pkg;

  typedef enum logic [2:0] {
    CLS_UNDEFINED = 3'd0,
    CLS_RAM       = 3'd1,
    CLS_RESERVED  = 3'd2,
    CLS_ACPI      = 3'd3,
    CLS_NVS       = 3'd4,
    CLS_UNUSABLE  = 3'd5
  } cls_e;

  typedef struct packed {
    logic [4:0]  efi_type;
    logic [63:0] phys_start;
    logic [51:0] num_pages;
    logic        last_descriptor;
  } desc_t;

  typedef struct packed {
    logic [63:0] region_addr;
    logic [63:0] entry_len;
    logic [2:0]  e820_class;
    logic        last_entry;
    logic        overflowed;
  } entry_out_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] len;
    logic [2:0]  cls;
  } ent_t;

  typedef struct packed {
    logic ins;
    logic shift;
    ent_t ent;
  } cell_ctl_t;

  function automatic logic [2:0] class_of_type(input logic [4:0] t);
    cls_e c;
    unique case (t)
      5'd1, 5'd2, 5'd3, 5'd4, 5'd7:        c = CLS_RAM;
      5'd0, 5'd5, 5'd6, 5'd11, 5'd12, 5'd13: c = CLS_RESERVED;
      5'd8:                                 c = CLS_UNUSABLE;
      5'd9:                                 c = CLS_ACPI;
      5'd10:                                c = CLS_NVS;
      default:                              c = CLS_UNDEFINED;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/memory_map_sort_merge_unit.sv =====
// Top level: sorting cell chain, downward merge walk and entry output.
`timescale 1ns / 1ps
// Insert: a descriptor is taken in S_IDLE and busy stays high through S_GAP, so no new
// descriptor is taken until S_IDLE returns. Last descriptor: after S_GAP the merge walks down
// the cell pairs, one cell pair per cycle (skipped below two entries); S_EMIT strobes the first entry.
// Then one entry per cycle; busy drops as the last one is strobed; no stall possible.
// Reset clears count, overflow flag and control; the cell contents are undefined.
module memory_map_sort_merge_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  mmsm_pkg::desc_t        desc_i,
  output logic                   result_valid_o,
  output mmsm_pkg::entry_out_t   result_o
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {S_IDLE, S_GAP, S_MERGE, S_EMIT} state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [IW-1:0]     idx_q;
  logic              ovf_q;
  logic              pend_last_q;

  mmsm_pkg::ent_t    ents [CAPACITY];
  mmsm_pkg::ent_t    prevs [CAPACITY];
  mmsm_pkg::cell_ctl_t ctls [CAPACITY];

  logic        acc;
  logic        room;
  mmsm_pkg::ent_t new_ent;
  logic [CAPACITY-1:0] gt;

  mmsm_pkg::ent_t lo_ent, hi_ent;
  logic [63:0] lo_end;
  logic        join_now;

  assign acc  = start && !busy;
  assign room = (count_q < CW'(CAPACITY));
  assign busy = (state_q != S_IDLE);

  always_comb begin
    new_ent.addr = desc_i.phys_start;
    new_ent.len  = {desc_i.num_pages, 12'd0};
    new_ent.cls  = mmsm_pkg::class_of_type(desc_i.efi_type);
  end

  // Merge walk: pair (idx-1, idx), with the upper entry at idx
  assign hi_ent   = ents[idx_q];
  assign lo_ent   = ents[idx_q - IW'(1)];
  assign lo_end   = lo_ent.addr + lo_ent.len;
  assign join_now = (hi_ent.cls == lo_ent.cls) && (lo_end >= hi_ent.addr);

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      gt[k] = (CW'(k) < count_q) && (new_ent.addr < ents[k].addr);
      prevs[k] = ents[k];
      ctls[k].ins = 1'b0;
      ctls[k].shift = 1'b0;
      ctls[k].ent = new_ent;
      if (k > 0) begin
        if (state_q == S_MERGE) begin
          prevs[k] = (k + 1 < CAPACITY) ? ents[(k + 1) % CAPACITY] : ents[k];
        end else begin
          prevs[k] = ents[k-1];
        end
      end
    end
    if (acc && room) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (CW'(k) <= count_q) begin
          if (gt[k] && (k == 0 || !gt[(k + CAPACITY - 1) % CAPACITY])) begin
            ctls[k].ins = 1'b1;
          end else if (k == int'(count_q) && (k == 0 || !gt[(k + CAPACITY - 1) % CAPACITY])) begin
            ctls[k].ins = 1'b1;
          end else if (k > 0 && gt[(k + CAPACITY - 1) % CAPACITY]) begin
            ctls[k].shift = 1'b1;
          end
        end
      end
    end else if (state_q == S_MERGE && join_now) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (IW'(k) == idx_q - IW'(1)) begin
          ctls[k].ins = 1'b1;
          ctls[k].ent = lo_ent;
          ctls[k].ent.len = lo_ent.len + hi_ent.len;
        end else if (k > 0 && IW'(k) >= idx_q) begin
          ctls[k].shift = 1'b1;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    mmsm_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctls[g]),
      .prev_i(prevs[g]),
      .ent_o (ents[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      idx_q          <= '0;
      ovf_q          <= 1'b0;
      pend_last_q    <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (room) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            pend_last_q <= desc_i.last_descriptor;
            state_q <= S_GAP;
          end
        end
        S_GAP: begin
          if (!pend_last_q) begin
            state_q <= S_IDLE;
          end else if (count_q >= CW'(2)) begin
            idx_q   <= IW'(count_q - CW'(1));
            state_q <= S_MERGE;
          end else if (count_q == '0) begin
            ovf_q   <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            idx_q   <= '0;
            state_q <= S_EMIT;
          end
        end
        S_MERGE: begin
          if (join_now) begin
            count_q <= count_q - CW'(1);
          end
          if (idx_q == IW'(1)) begin
            idx_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            idx_q <= idx_q - IW'(1);
          end
        end
        S_EMIT: begin
          result_valid_o       <= 1'b1;
          result_o.region_addr <= ents[idx_q].addr;
          result_o.entry_len   <= ents[idx_q].len;
          result_o.e820_class  <= ents[idx_q].cls;
          result_o.overflowed  <= ovf_q;
          result_o.last_entry  <= (CW'(idx_q) + CW'(1) == count_q);
          if (CW'(idx_q) + CW'(1) == count_q) begin
            count_q <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/mmsm_cell.sv =====
// Sort cell: holds one entry, takes a given word or a neighbour's entry (lower on insert, upper in merge).
`timescale 1ns / 1ps
module mmsm_cell (
  input  logic                clk_i,
  input  mmsm_pkg::cell_ctl_t ctl_i,
  input  mmsm_pkg::ent_t      prev_i,
  output mmsm_pkg::ent_t      ent_o
);
  mmsm_pkg::ent_t ent_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      ent_q <= ctl_i.ent;
    end else if (ctl_i.shift) begin
      ent_q <= prev_i;
    end
  end

  assign ent_o = ent_q;
endmodule
